// File: design/b32e_pkg.sv
// Shared types, constants and functions of the bech32 address encoder.
// Holds the checksum generator, the character set and the sequencer states.
// No dependencies.
package b32e_pkg;

  // Prefix store depth and the widths that follow from it
  localparam int PREFIX_MAX = 32;
  localparam int PFX_W      = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
  localparam int LEN_W      = $clog2(PREFIX_MAX + 1);

  // Transaction function codes
  localparam logic [1:0] FUNC_PREFIX = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  // Separator character '1'
  localparam logic [7:0] SEP_CHAR = 8'h31;

  // Number of checksum characters, also the number of trailing zero folds
  localparam int         CSUM_CHARS = 6;
  localparam logic [2:0] CSUM_LAST  = 3'(CSUM_CHARS - 1);

  localparam logic [29:0] GEN_POLY [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  // qpzry9x8gf2tvdw0s3jn54khce6mua7l
  localparam logic [7:0] CHARSET [32] = '{
    8'h71, 8'h70, 8'h7a, 8'h72, 8'h79, 8'h39, 8'h78, 8'h38,
    8'h67, 8'h66, 8'h32, 8'h74, 8'h76, 8'h64, 8'h77, 8'h30,
    8'h73, 8'h33, 8'h6a, 8'h6e, 8'h35, 8'h34, 8'h6b, 8'h68,
    8'h63, 8'h65, 8'h36, 8'h6d, 8'h75, 8'h61, 8'h37, 8'h6c
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREFIX,
    S_SEP,
    S_FOLD,
    S_DATA,
    S_PAD,
    S_MIX,
    S_CHECK
  } b32e_state_e;

  // One polymod step: shift the checksum by one 5-bit group
  function automatic logic [29:0] poly_step(input logic [29:0] c);
    logic [4:0]  top;
    logic [29:0] r;
    top = c[29:25];
    r   = {c[24:0], 5'b0};
    for (int i = 0; i < 5; i++) begin
      if (top[i]) begin
        r = r ^ GEN_POLY[i];
      end
    end
    return r;
  endfunction

endpackage

// File: design/b32e_in_if.sv
// Input channel of the bech32 address encoder: function code and value byte.
// Depends on nothing.
interface b32e_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

// File: design/b32e_out_if.sv
// Output channel of the bech32 address encoder: one character per transaction.
// Depends on nothing.
interface b32e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic       error;

  modport source (output valid, output character, output last, output error, input ready);
  modport sink   (input valid, input character, input last, input error, output ready);
endinterface

// File: design/bech32_address_encoder_core.sv
// Streaming bech32 encoder. A prefix item echoes its character or flags an error; a
// data item emits one or two characters. The first data or finish item adds the
// separator and the fold, which walks the prefix store at one entry per cycle through
// its single read port. Finish pads, runs six polymod steps and emits six checksum
// characters. Output stalls hold every step that emits a character. Reset (rst_ni
// low) clears control state.
module bech32_address_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  b32e_in_if.sink     in_i,
  b32e_out_if.source  out_o
);
  import b32e_pkg::*;

  b32e_state_e state_q, state_d;

  logic [29:0]      cs_q, cs_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             dp_q, dp_d;
  logic [3:0]       lo_bits_q, lo_bits_d;
  logic [2:0]       lo_cnt_q, lo_cnt_d;
  logic [11:0]      acc_q, acc_d;
  logic [3:0]       bits_q, bits_d;
  logic [PFX_W-1:0] idx_q, idx_d;
  logic [2:0]       step_q, step_d;
  logic [1:0]       func_q, func_d;
  logic [7:0]       value_q, value_d;

  // Prefix low-group store
  logic [4:0]       mem [PREFIX_MAX];
  logic [4:0]       rd_data_q;
  logic [PFX_W-1:0] rd_addr;
  logic             mem_we;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_last_q, out_err_q;

  logic       in_fire, out_free, reject, fold_done;
  logic       emit, emit_last, emit_err;
  logic [7:0] emit_char;
  logic [3:0] bits_n;
  logic [4:0] grp;

  assign in_i.ready      = (state_q == S_IDLE);
  assign in_fire         = in_i.valid && in_i.ready;
  assign out_free        = !out_valid_q || out_o.ready;
  assign reject          = dp_q || (len_q == LEN_W'(PREFIX_MAX));
  assign fold_done       = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);
  assign bits_n          = bits_q - 4'd5;
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;
  assign out_o.error     = out_err_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.func)
            FUNC_PREFIX: state_d = S_PREFIX;
            FUNC_DATA:   state_d = dp_q ? S_DATA : S_SEP;
            FUNC_FINISH: state_d = dp_q ? S_PAD : S_SEP;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_PREFIX: if (out_free) state_d = S_IDLE;
      S_SEP: begin
        if (out_free) begin
          if (len_q != '0) state_d = S_FOLD;
          else             state_d = (func_q == FUNC_DATA) ? S_DATA : S_PAD;
        end
      end
      S_FOLD: if (fold_done) state_d = (func_q == FUNC_DATA) ? S_DATA : S_PAD;
      S_DATA: if (out_free && bits_n < 4'd5) state_d = S_IDLE;
      S_PAD:  if (lo_cnt_q == '0 || out_free) state_d = S_MIX;
      S_MIX:  if (step_q == CSUM_LAST) state_d = S_CHECK;
      S_CHECK: if (out_free && step_q == CSUM_LAST) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and emitted characters
  always_comb begin
    cs_d      = cs_q;
    len_d     = len_q;
    dp_d      = dp_q;
    lo_bits_d = lo_bits_q;
    lo_cnt_d  = lo_cnt_q;
    acc_d     = acc_q;
    bits_d    = bits_q;
    idx_d     = idx_q;
    step_d    = step_q;
    func_d    = func_q;
    value_d   = value_q;
    mem_we    = 1'b0;
    rd_addr   = '0;
    emit      = 1'b0;
    emit_char = '0;
    emit_last = 1'b0;
    emit_err  = 1'b0;
    grp       = '0;
    case (state_q)
      S_IDLE: begin
        // capture the transaction
        if (in_fire) begin
          func_d  = in_i.func;
          value_d = in_i.value;
          acc_d   = {lo_bits_q, in_i.value};
          bits_d  = 4'(lo_cnt_q) + 4'd8;
        end
      end
      S_PREFIX: begin
        // echo or reject, fold high bits, store low bits
        if (out_free) begin
          emit = 1'b1;
          if (reject) begin
            emit_err = 1'b1;
          end else begin
            emit_char = value_q;
            cs_d      = poly_step(cs_q) ^ {27'b0, value_q[7:5]};
            mem_we    = 1'b1;
            len_d     = len_q + LEN_W'(1);
          end
        end
      end
      S_SEP: begin
        // emit the separator, fold the zero group, start reading the store
        if (out_free) begin
          emit      = 1'b1;
          emit_char = SEP_CHAR;
          cs_d      = poly_step(cs_q);
          idx_d     = '0;
          if (len_q == '0) dp_d = 1'b1;
        end
      end
      S_FOLD: begin
        // fold one stored low group per cycle, prefetch the next entry
        cs_d    = poly_step(cs_q) ^ {25'b0, rd_data_q};
        idx_d   = idx_q + PFX_W'(1);
        rd_addr = idx_q + PFX_W'(1);
        if (fold_done) dp_d = 1'b1;
      end
      S_DATA: begin
        // emit one regrouped 5-bit group per cycle while the output is free
        if (out_free) begin
          grp       = 5'(acc_q >> bits_n);
          emit      = 1'b1;
          emit_char = CHARSET[grp];
          cs_d      = poly_step(cs_q) ^ {25'b0, grp};
          bits_d    = bits_n;
          if (bits_n < 4'd5) begin
            lo_bits_d = acc_q[3:0] & 4'((5'd1 << bits_n[2:0]) - 5'd1);
            lo_cnt_d  = bits_n[2:0];
          end
        end
      end
      S_PAD: begin
        // flush leftover bits padded with zeros
        step_d = '0;
        if (lo_cnt_q != '0 && out_free) begin
          grp       = 5'({1'b0, lo_bits_q} << (3'd5 - lo_cnt_q));
          emit      = 1'b1;
          emit_char = CHARSET[grp];
          cs_d      = poly_step(cs_q) ^ {25'b0, grp};
          lo_bits_d = '0;
          lo_cnt_d  = '0;
        end
      end
      S_MIX: begin
        // six zero folds, then the final constant
        step_d = step_q + 3'd1;
        cs_d   = poly_step(cs_q);
        if (step_q == CSUM_LAST) begin
          cs_d   = poly_step(cs_q) ^ 30'd1;
          step_d = '0;
        end
      end
      S_CHECK: begin
        // emit checksum characters, top group first; clear for the next address
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CHARSET[cs_q[29:25]];
          cs_d      = {cs_q[24:0], 5'b0};
          step_d    = step_q + 3'd1;
          if (step_q == CSUM_LAST) begin
            emit_last = 1'b1;
            cs_d      = 30'd1;
            len_d     = '0;
            dp_d      = 1'b0;
            lo_bits_d = '0;
            lo_cnt_d  = '0;
            step_d    = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cs_q        <= 30'd1;
      len_q       <= '0;
      dp_q        <= 1'b0;
      lo_bits_q   <= '0;
      lo_cnt_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cs_q      <= cs_d;
      len_q     <= len_d;
      dp_q      <= dp_d;
      lo_bits_q <= lo_bits_d;
      lo_cnt_q  <= lo_cnt_d;
      step_q    <= step_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    bits_q  <= bits_d;
    idx_q   <= idx_d;
    func_q  <= func_d;
    value_q <= value_d;
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
      out_err_q  <= emit_err;
    end
  end

  // Prefix store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[len_q[PFX_W-1:0]] <= value_q[4:0];
    end
    rd_data_q <= mem[rd_addr];
  end

endmodule

// File: design/b32e_checker.sv
// Port-level checks of the bech32 address encoder, bound to the top level.
// Depends on b32e_pkg and the top level's channel interfaces.
module b32e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_func_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_character_i,
  input logic       out_last_i,
  input logic       out_error_i
);
  import b32e_pkg::*;

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_character_i) && $stable(out_last_i) && $stable(out_error_i))
    else $error("output transaction changed while stalled");

  // A rejected prefix character carries a zero code and no end mark
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_error_i |-> out_character_i == 8'h00 && !out_last_i)
    else $error("error result with non-zero character or end mark");

  // Any accepted transaction with a defined function keeps the input closed next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == FUNC_PREFIX || in_func_i == FUNC_DATA ||
      in_func_i == FUNC_FINISH) |=> !in_ready_i)
    else $error("input accepted again while a transaction is in work");

  // The end mark can only rise out of a state in which the input was closed
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i && !$past(out_valid_i && out_last_i) |-> !$past(in_ready_i))
    else $error("end mark appeared without a finish in work");

endmodule

bind bech32_address_encoder_core b32e_checker u_b32e_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_func_i       (in_i.func),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_character_i (out_o.character),
  .out_last_i      (out_o.last),
  .out_error_i     (out_o.error)
);
